/* rtl/mcg_pkg.sv */
`timescale 1ns / 1ps
// Package for the midpoint circle generator: widths, step constants, codes,
// the sequencer state type and the request type of the shared arithmetic unit.
// No dependencies.
package mcg_pkg;

   localparam int COORD_BITS = 10;

   localparam int CEN_W   = COORD_BITS + 1;       // centre coordinate
   localparam int OCT_W   = COORD_BITS + 1;       // octant point, signed
   localparam int DEC_W   = COORD_BITS + 6;       // decision variable, signed
   localparam int PIX_W   = COORD_BITS + 2;       // plotted pixel, signed
   localparam int PROD_W  = 2 * COORD_BITS;       // one box product
   localparam int ALU_W   = 2 * COORD_BITS + 2;   // shared unit datapath
   localparam int REM_W   = COORD_BITS + 4;       // root and divide remainder
   localparam int ROOT_W  = COORD_BITS + 1;       // integer square root

   localparam int SQRT_STEPS = ALU_W / 2;
   localparam int DIV_STEPS  = PROD_W;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   localparam int PIX_PER_STEP = 8;
   localparam int IDX_W        = $clog2(PIX_PER_STEP);

   localparam int DEC_INIT = 3;
   localparam int STEP_NEG = 6;
   localparam int STEP_POS = 10;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_WW,
      ST_MUL_HH,
      ST_SUM,
      ST_MUL_WH,
      ST_SQRT,
      ST_DIV,
      ST_INIT,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL
   } alu_op_type;

   typedef struct packed {
      alu_op_type              op;
      logic signed [ALU_W-1:0] a;
      logic signed [ALU_W-1:0] b;
   } alu_req_type;

endpackage

/* rtl/midpoint_circle_generator_top.sv */
`timescale 1ns / 1ps
// Top level of the midpoint circle generator: request sequencer, circle state
// and registered result port. Uses mcg_pkg and the shared unit mcg_alu.
//
// A request is taken when start is high and busy is low. A start request
// (op 0) latches the centre and computes the radius of the circle inscribed in
// the rhombus of the box; it returns nothing and keeps busy high through the
// three products and the sum, 11 square-root iterations, 20 divide iterations
// and the seeding of the decision term, or for a single cycle when the width
// or the height is zero. A step request (op 1) returns the eight mirrored
// pixels of the current point on consecutive cycles, through the emit state
// and then the result register, and keeps busy high while emitting, so a new
// step is taken only once busy drops. A step with no circle in progress,
// or once the point has passed the diagonal, returns one done result in the
// cycle after acceptance and does not raise busy. All of this work runs
// through one adder/multiplier unit under the sequencer, one operation per
// cycle, which sets how long busy stays high. Results carry rsp_strobe for
// exactly one cycle; the receiver cannot hold them off and must take each one
// when it appears. Pixels are not clipped and wrap in 12-bit two's complement.
module midpoint_circle_generator_top
   import mcg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_op,
   input  logic [COORD_BITS-1:0]   req_corner_x,
   input  logic [COORD_BITS-1:0]   req_corner_y,
   input  logic [COORD_BITS-1:0]   req_box_width,
   input  logic [COORD_BITS-1:0]   req_box_height,
   output logic                    rsp_strobe,
   output logic signed [PIX_W-1:0] rsp_pixel_x,
   output logic signed [PIX_W-1:0] rsp_pixel_y,
   output logic                    rsp_last_of_step,
   output logic                    rsp_done_res
);

   // Sequencer state.
   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   // Circle state.
   logic [CEN_W-1:0]        centre_x_ff, centre_x_in;
   logic [CEN_W-1:0]        centre_y_ff, centre_y_in;
   logic signed [OCT_W-1:0] x_ff, x_in;
   logic signed [OCT_W-1:0] y_ff, y_in;
   logic signed [DEC_W-1:0] decision_ff, decision_in;
   logic                    drawing_ff, drawing_in;

   // Working registers for the radius and the point update.
   logic [COORD_BITS-1:0]   w_ff, w_in;
   logic [COORD_BITS-1:0]   h_ff, h_in;
   logic                    degen_ff, degen_in;
   logic signed [ALU_W-1:0] acc_ff, acc_in;
   logic signed [ALU_W-1:0] tmp_ff, tmp_in;
   logic [PROD_W-1:0]       q_ff, q_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [ROOT_W-1:0]       root_ff, root_in;
   logic                    neg_ff, neg_in;
   logic signed [OCT_W-1:0] x_next_ff, x_next_in;
   logic signed [OCT_W-1:0] y_next_ff, y_next_in;

   // Result register.
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic signed [PIX_W-1:0] rsp_pixel_x_ff, rsp_pixel_x_in;
   logic signed [PIX_W-1:0] rsp_pixel_y_ff, rsp_pixel_y_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_done_ff, rsp_done_in;

   alu_req_type             alu_req;
   logic signed [ALU_W-1:0] alu_res;

   logic [REM_W-1:0]  rem_shift;
   logic [REM_W-1:0]  trial;
   logic [OCT_W-1:0]  r_src;
   logic [PIX_W-1:0]  cen_x_pix, cen_y_pix, ox_pix, oy_pix;
   logic [PIX_W-1:0]  dx_src, dy_src;
   logic              dx_neg, dy_neg;
   logic              done_cond;

   mcg_alu u_alu (
      .alu_req (alu_req),
      .alu_res (alu_res)
   );

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_pixel_x      = rsp_pixel_x_ff;
   assign rsp_pixel_y      = rsp_pixel_y_ff;
   assign rsp_last_of_step = rsp_last_ff;
   assign rsp_done_res     = rsp_done_ff;

   assign cen_x_pix = PIX_W'(centre_x_ff);
   assign cen_y_pix = PIX_W'(centre_y_ff);
   assign ox_pix    = PIX_W'(x_ff);
   assign oy_pix    = PIX_W'(y_ff);
   assign r_src     = degen_ff ? '0 : q_ff[OCT_W-1:0];

   // The eight mirrored pixels of one point, in emission order.
   always_comb begin
      case (idx_ff)
         3'd0:    begin dx_src = ox_pix; dx_neg = 1'b0; dy_src = oy_pix; dy_neg = 1'b0; end
         3'd1:    begin dx_src = oy_pix; dx_neg = 1'b0; dy_src = ox_pix; dy_neg = 1'b0; end
         3'd2:    begin dx_src = oy_pix; dx_neg = 1'b1; dy_src = ox_pix; dy_neg = 1'b0; end
         3'd3:    begin dx_src = ox_pix; dx_neg = 1'b1; dy_src = oy_pix; dy_neg = 1'b0; end
         3'd4:    begin dx_src = ox_pix; dx_neg = 1'b1; dy_src = oy_pix; dy_neg = 1'b1; end
         3'd5:    begin dx_src = oy_pix; dx_neg = 1'b1; dy_src = ox_pix; dy_neg = 1'b1; end
         3'd6:    begin dx_src = ox_pix; dx_neg = 1'b0; dy_src = oy_pix; dy_neg = 1'b1; end
         default: begin dx_src = oy_pix; dx_neg = 1'b0; dy_src = ox_pix; dy_neg = 1'b1; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         idx_ff        <= '0;
         drawing_ff    <= 1'b0;
         centre_x_ff   <= '0;
         centre_y_ff   <= '0;
         x_ff          <= '0;
         y_ff          <= '0;
         decision_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         idx_ff        <= idx_in;
         drawing_ff    <= drawing_in;
         centre_x_ff   <= centre_x_in;
         centre_y_ff   <= centre_y_in;
         x_ff          <= x_in;
         y_ff          <= y_in;
         decision_ff   <= decision_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff           <= w_in;
      h_ff           <= h_in;
      degen_ff       <= degen_in;
      acc_ff         <= acc_in;
      tmp_ff         <= tmp_in;
      q_ff           <= q_in;
      rem_ff         <= rem_in;
      root_ff        <= root_in;
      neg_ff         <= neg_in;
      x_next_ff      <= x_next_in;
      y_next_ff      <= y_next_in;
      rsp_pixel_x_ff <= rsp_pixel_x_in;
      rsp_pixel_y_ff <= rsp_pixel_y_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_done_ff    <= rsp_done_in;
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      idx_in         = idx_ff;
      drawing_in     = drawing_ff;
      centre_x_in    = centre_x_ff;
      centre_y_in    = centre_y_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      decision_in    = decision_ff;
      w_in           = w_ff;
      h_in           = h_ff;
      degen_in       = degen_ff;
      acc_in         = acc_ff;
      tmp_in         = tmp_ff;
      q_in           = q_ff;
      rem_in         = rem_ff;
      root_in        = root_ff;
      neg_in         = neg_ff;
      x_next_in      = x_next_ff;
      y_next_in      = y_next_ff;
      rsp_strobe_in  = 1'b0;
      rsp_pixel_x_in = rsp_pixel_x_ff;
      rsp_pixel_y_in = rsp_pixel_y_ff;
      rsp_last_in    = 1'b0;
      rsp_done_in    = 1'b0;
      rem_shift      = '0;
      trial          = '0;

      // While idle the unit forms y - x; a negative result means the point
      // has crossed the diagonal.
      alu_req.op = ALU_SUB;
      alu_req.a  = ALU_W'(y_ff);
      alu_req.b  = ALU_W'(x_ff);
      done_cond  = !drawing_ff || alu_res[ALU_W-1];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_op == OP_START) begin
                  w_in        = req_box_width;
                  h_in        = req_box_height;
                  centre_x_in = CEN_W'(req_corner_x) + CEN_W'(req_box_width >> 1);
                  centre_y_in = CEN_W'(req_corner_y) + CEN_W'(req_box_height >> 1);
                  x_in        = '0;
                  drawing_in  = 1'b1;
                  degen_in    = (req_box_width == '0) || (req_box_height == '0);
                  state_in    = degen_in ? ST_INIT : ST_MUL_WW;
               end else if (done_cond) begin
                  rsp_strobe_in  = 1'b1;
                  rsp_done_in    = 1'b1;
                  rsp_pixel_x_in = '0;
                  rsp_pixel_y_in = '0;
                  drawing_in     = 1'b0;
               end else begin
                  idx_in   = '0;
                  state_in = ST_EMIT;
               end
            end
         end

         ST_MUL_WW: begin
            alu_req.op = ALU_MUL;
            alu_req.a  = ALU_W'(w_ff);
            alu_req.b  = ALU_W'(w_ff);
            acc_in     = alu_res;
            state_in   = ST_MUL_HH;
         end

         ST_MUL_HH: begin
            alu_req.op = ALU_MUL;
            alu_req.a  = ALU_W'(h_ff);
            alu_req.b  = ALU_W'(h_ff);
            tmp_in     = alu_res;
            state_in   = ST_SUM;
         end

         ST_SUM: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = acc_ff;
            alu_req.b  = tmp_ff;
            acc_in     = alu_res;
            state_in   = ST_MUL_WH;
         end

         ST_MUL_WH: begin
            alu_req.op = ALU_MUL;
            alu_req.a  = ALU_W'(w_ff);
            alu_req.b  = ALU_W'(h_ff);
            q_in       = alu_res[PROD_W-1:0];
            rem_in     = '0;
            root_in    = '0;
            cnt_in     = '0;
            state_in   = ST_SQRT;
         end

         // Digit-by-digit square root, two radicand bits per cycle.
         ST_SQRT: begin
            rem_shift  = {rem_ff[REM_W-3:0], acc_ff[ALU_W-1 -: 2]};
            trial      = REM_W'({root_ff, 2'b01});
            alu_req.op = ALU_SUB;
            alu_req.a  = ALU_W'(rem_shift);
            alu_req.b  = ALU_W'(trial);
            acc_in     = acc_ff <<< 2;
            if (alu_res[ALU_W-1]) begin
               rem_in  = rem_shift;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end else begin
               rem_in  = alu_res[REM_W-1:0];
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) begin
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end

         // Restoring divide of w*h by twice the root, one quotient bit a cycle.
         ST_DIV: begin
            rem_shift  = {rem_ff[REM_W-2:0], q_ff[PROD_W-1]};
            alu_req.op = ALU_SUB;
            alu_req.a  = ALU_W'(rem_shift);
            alu_req.b  = ALU_W'({root_ff, 1'b0});
            if (alu_res[ALU_W-1]) begin
               rem_in = rem_shift;
               q_in   = {q_ff[PROD_W-2:0], 1'b0};
            end else begin
               rem_in = alu_res[REM_W-1:0];
               q_in   = {q_ff[PROD_W-2:0], 1'b1};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_INIT;
            end
         end

         ST_INIT: begin
            alu_req.op  = ALU_SUB;
            alu_req.a   = ALU_W'(DEC_INIT);
            alu_req.b   = ALU_W'({r_src, 1'b0});
            y_in        = r_src;
            decision_in = alu_res[DEC_W-1:0];
            state_in    = ST_IDLE;
         end

         // One pixel per cycle; the point update is spread over the same cycles
         // and is committed with the eighth pixel.
         ST_EMIT: begin
            rsp_strobe_in  = 1'b1;
            rsp_pixel_x_in = dx_neg ? cen_x_pix - dx_src : cen_x_pix + dx_src;
            rsp_pixel_y_in = dy_neg ? cen_y_pix - dy_src : cen_y_pix + dy_src;
            rsp_last_in    = (idx_ff == IDX_W'(PIX_PER_STEP - 1));
            idx_in         = idx_ff + 1'b1;
            case (idx_ff)
               3'd0: begin
                  neg_in     = decision_ff[DEC_W-1];
                  alu_req.op = ALU_ADD;
                  alu_req.a  = ALU_W'(x_ff) <<< 2;
                  alu_req.b  = decision_ff[DEC_W-1] ? ALU_W'(STEP_NEG) : ALU_W'(STEP_POS);
                  tmp_in     = alu_res;
               end
               3'd1: begin
                  alu_req.op = ALU_SUB;
                  alu_req.a  = tmp_ff;
                  alu_req.b  = neg_ff ? '0 : (ALU_W'(y_ff) <<< 2);
                  tmp_in     = alu_res;
               end
               3'd2: begin
                  alu_req.op  = ALU_ADD;
                  alu_req.a   = ALU_W'(decision_ff);
                  alu_req.b   = tmp_ff;
                  decision_in = alu_res[DEC_W-1:0];
               end
               3'd3: begin
                  alu_req.op = ALU_SUB;
                  alu_req.a  = ALU_W'(y_ff);
                  alu_req.b  = neg_ff ? '0 : ALU_W'(1);
                  y_next_in  = alu_res[OCT_W-1:0];
               end
               3'd4: begin
                  alu_req.op = ALU_ADD;
                  alu_req.a  = ALU_W'(x_ff);
                  alu_req.b  = ALU_W'(1);
                  x_next_in  = alu_res[OCT_W-1:0];
               end
               default: begin
               end
            endcase
            if (idx_ff == IDX_W'(PIX_PER_STEP - 1)) begin
               x_in     = x_next_ff;
               y_in     = y_next_ff;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Every cycle spent emitting is followed by a pixel on the result port.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |=> (rsp_strobe && !rsp_done_res))
      else $error("pixel cycle did not produce a strobed pixel");

   // A start request always occupies the sequencer for at least a cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_START)) |=> busy)
      else $error("start request did not raise busy");

   // The last-of-step mark only rides on a pixel result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_last_of_step |-> (rsp_strobe && !rsp_done_res && $past(state_ff == ST_EMIT)))
      else $error("last mark outside a pixel result");

   // A done result always leaves no circle in progress.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_done_res) |-> !drawing_ff)
      else $error("done result while a circle is still active");

   // The divide remainder stays below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < REM_W'({root_ff, 1'b0})))
      else $error("divide remainder out of range");

endmodule

/* rtl/mcg_alu.sv */
`timescale 1ns / 1ps
// Shared arithmetic unit of the circle generator: add, subtract, or a
// narrow unsigned multiply of the low coordinate bits. Uses mcg_pkg.
module mcg_alu
   import mcg_pkg::*;
(
   input  alu_req_type             alu_req,
   output logic signed [ALU_W-1:0] alu_res
);

   logic [PROD_W-1:0] prod;

   assign prod = alu_req.a[COORD_BITS-1:0] * alu_req.b[COORD_BITS-1:0];

   always_comb begin
      unique case (alu_req.op)
         ALU_ADD: alu_res = alu_req.a + alu_req.b;
         ALU_SUB: alu_res = alu_req.a - alu_req.b;
         ALU_MUL: alu_res = ALU_W'(prod);
         default: alu_res = '0;
      endcase
   end

endmodule
